// ----- rtl/core/route_table_with_aging_unit_assert.svh -----
// Assertion macros for the route table with aging unit.
`ifndef ROUTE_TABLE_WITH_AGING_UNIT_ASSERT_SVH
`define ROUTE_TABLE_WITH_AGING_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define RTWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTWA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define RTWA_ASSERT(lbl, prop, msg)
`define RTWA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/rtwa_pkg.sv -----
// Shared types and constants of the route table with aging unit.
`default_nettype none

package rtwa_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam logic [31:0] TIMEOUT_RESET     = 32'd600000;
  localparam int unsigned COUNT_OUT_W       = 5;

  typedef enum logic [1:0] {
    FUNC_ADD     = 2'd0,
    FUNC_FIND    = 2'd1,
    FUNC_REFRESH = 2'd2,
    FUNC_AGE     = 2'd3
  } func_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [31:0]        seen;
    logic signed [7:0]  strength;
    logic [7:0]         hops;
    logic [15:0]        hop;
    logic [15:0]        dest;
  } route_t;

  typedef struct packed {
    logic [31:0]        now_time;
    logic signed [7:0]  strength_in;
    logic [7:0]         hops_in;
    logic [15:0]        hop_addr_in;
    logic [15:0]        dest_addr;
  } req_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [31:0]            seen_out;
    logic signed [7:0]      strength_out;
    logic [7:0]             hops_out;
    logic [15:0]            hop_addr_out;
    logic [1:0]             status;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/route_table_with_aging_unit.sv -----
// Top level of the route table with aging unit.
`default_nettype none
`include "route_table_with_aging_unit_assert.svh"

// Keeps an ordered, packed table of up to TABLE_ENTRIES routes in a memory with one registered
// read port and applies one add, find, refresh or age-out operation per item. The sequencer
// walks the table one entry at a time, reading each entry from memory and then comparing it.
// The walk visits entries up to the match for add, find and refresh, and all valid entries
// for age-out and for a miss. The result is registered on the output, and the block accepts
// the next item from the cycle in which that result appears. While an earlier result still
// waits on out_tready the block holds its own result back and stays busy. The table needs no
// clearing pass after reset. Configuration writes are accepted in every cycle but should only
// be made while no item is in flight.
module route_table_with_aging_unit #(
  parameter int unsigned TABLE_ENTRIES = rtwa_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // dest_addr[15:0], hop_addr_in[31:16], hops_in[39:32], strength_in[47:40],
  // now_time[79:48]
  input  wire logic [79:0] in_tdata,
  // func[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[1:0], hop_addr_out[17:2], hops_out[25:18], strength_out[33:26],
  // seen_out[65:34], entry_count[70:66], zero[71]
  output logic [71:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  import rtwa_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [31:0]      timeout_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_data_r;

  logic             start;
  logic             out_free;
  logic             idle;
  logic             res_valid;
  result_t          res;
  logic [CNT_W-1:0] used_count;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  route_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  route_t           wr_data;

  assign in_tready     = idle;
  assign start         = in_tvalid && in_tready;
  assign out_free      = !out_valid_r || out_tready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_tready);
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  rtwa_seq #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .op_func    (func_t'(in_tuser)),
    .op_req     (req_t'(in_tdata)),
    .timeout    (timeout_r),
    .out_free   (out_free),
    .idle       (idle),
    .res_valid  (res_valid),
    .res        (res),
    .used_count (used_count),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  rtwa_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  `RTWA_ASSERT(a_used_bound, used_count <= CNT_W'(TABLE_ENTRIES), "Route count exceeds table size.")
  `RTWA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "Ready after accept.")
  `RTWA_ASSERT(a_status_code, !out_tvalid || out_tdata[1:0] != 2'd3, "Illegal status code.")
  `RTWA_ASSERT(a_load_when_free, !res_valid || !out_valid_r || out_tready, "Result overwritten.")

endmodule

`default_nettype wire

// ----- rtl/core/rtwa_table.sv -----
// Route entry memory with one write port and one registered read port.
`default_nettype none

module rtwa_table #(
  parameter int unsigned TABLE_ENTRIES = rtwa_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire rtwa_pkg::route_t wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output rtwa_pkg::route_t      rd_data
);
  import rtwa_pkg::*;

  route_t mem_r [TABLE_ENTRIES];
  route_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/rtwa_seq.sv -----
// Sequencer that walks the route memory and applies one operation per item.
`default_nettype none

module rtwa_seq #(
  parameter int unsigned TABLE_ENTRIES = rtwa_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire rtwa_pkg::func_t  op_func,
  input  wire rtwa_pkg::req_t   op_req,
  input  wire logic [31:0]      timeout,
  input  wire logic             out_free,
  output logic                  idle,
  output logic                  res_valid,
  output rtwa_pkg::result_t     res,
  output logic [CNT_W-1:0]      used_count,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  wire rtwa_pkg::route_t rd_data,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output rtwa_pkg::route_t      wr_data
);
  import rtwa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] wptr_r, wptr_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  result_t          res_r, res_nxt;
  func_t            func_r;
  req_t             req_r;

  logic             hit;
  logic [31:0]      age;
  logic             stale;
  route_t           new_entry;
  route_t           upd_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    wptr_r <= wptr_nxt;
    res_r  <= res_nxt;
    if (start && idle) begin
      func_r <= op_func;
      req_r  <= op_req;
    end
  end

  always_comb begin
    hit   = (rd_data.dest == req_r.dest_addr);
    age   = req_r.now_time - rd_data.seen;
    stale = (age > timeout);

    new_entry.dest     = req_r.dest_addr;
    new_entry.hop      = req_r.hop_addr_in;
    new_entry.hops     = req_r.hops_in;
    new_entry.strength = req_r.strength_in;
    new_entry.seen     = req_r.now_time;

    upd_entry          = rd_data;
    upd_entry.strength = req_r.strength_in;
    upd_entry.seen     = req_r.now_time;
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    wptr_nxt  = wptr_r;
    used_nxt  = used_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = k_r[IDX_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = k_r[IDX_W-1:0];
    wr_data   = new_entry;
    res_valid = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          k_nxt     = '0;
          wptr_nxt  = '0;
          res_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (k_r < used_r) begin
          rd_en     = 1'b1;
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_DONE;
          case (func_r)
            FUNC_ADD: begin
              if (used_r < CNT_W'(TABLE_ENTRIES)) begin
                wr_en    = 1'b1;
                wr_addr  = used_r[IDX_W-1:0];
                used_nxt = used_r + CNT_W'(1);
              end else begin
                res_nxt.status = STATUS_FULL;
              end
            end
            FUNC_FIND, FUNC_REFRESH: begin
              res_nxt.status = STATUS_NOT_FOUND;
            end
            FUNC_AGE: begin
              used_nxt = wptr_r;
            end
            default: begin
              res_nxt.status = STATUS_OK;
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (func_r == FUNC_AGE) begin
          if (!stale) begin
            wr_en    = 1'b1;
            wr_addr  = wptr_r[IDX_W-1:0];
            wr_data  = rd_data;
            wptr_nxt = wptr_r + CNT_W'(1);
          end
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = ST_SCAN;
        end else if (hit) begin
          state_nxt = ST_DONE;
          case (func_r)
            FUNC_ADD: begin
              wr_en = (req_r.hops_in < rd_data.hops);
            end
            FUNC_FIND: begin
              res_nxt.hop_addr_out = rd_data.hop;
              res_nxt.hops_out     = rd_data.hops;
              res_nxt.strength_out = rd_data.strength;
              res_nxt.seen_out     = rd_data.seen;
            end
            FUNC_REFRESH: begin
              wr_en                = 1'b1;
              wr_data              = upd_entry;
              res_nxt.hop_addr_out = upd_entry.hop;
              res_nxt.hops_out     = upd_entry.hops;
              res_nxt.strength_out = upd_entry.strength;
              res_nxt.seen_out     = upd_entry.seen;
            end
            default: begin
              wr_en = 1'b0;
            end
          endcase
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res             = res_r;
    res.entry_count = COUNT_OUT_W'(used_r);
  end

  assign idle       = (state_r == ST_IDLE);
  assign used_count = used_r;

endmodule

`default_nettype wire

// ----- test/route_table_with_aging_unit_tb.sv -----
// Self-checking testbench for the route table with aging unit.
`timescale 1ns / 1ps

module route_table_with_aging_unit_tb;
  import rtwa_pkg::*;

  typedef struct {
    func_t op;
    req_t  req;
  } route_request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = FUNC_ADD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  route_request_t queued_requests[$];
  result_t        awaited_replies[$];
  route_request_t bus_request;
  logic           request_on_bus = 1'b0;
  int             burst_left = 1;
  int             gap_left = 0;
  logic [5:0]     stall_tick = '0;
  int             mismatch_count = 0;
  result_t        seen_reply;
  result_t        wanted_reply;

  logic [15:0] shadow_dest     [TABLE_ENTRIES_DEF];
  logic [15:0] shadow_hop      [TABLE_ENTRIES_DEF];
  logic [7:0]  shadow_hops     [TABLE_ENTRIES_DEF];
  logic [7:0]  shadow_strength [TABLE_ENTRIES_DEF];
  logic [31:0] shadow_seen     [TABLE_ENTRIES_DEF];
  int          shadow_count = 0;
  logic [31:0] shadow_timeout = TIMEOUT_RESET;

  route_table_with_aging_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t route_table_step(route_request_t r);
    result_t     res;
    int          slot;
    int          wr;
    logic        report;
    logic [31:0] age;
    res = '0;
    report = 1'b0;
    slot = -1;
    for (int k = 0; k < shadow_count; k++) begin
      if (slot < 0 && shadow_dest[k] == r.req.dest_addr) begin
        slot = k;
      end
    end
    case (r.op)
      FUNC_ADD: begin
        if (slot >= 0) begin
          if (r.req.hops_in < shadow_hops[slot]) begin
            shadow_hop[slot] = r.req.hop_addr_in;
            shadow_hops[slot] = r.req.hops_in;
            shadow_strength[slot] = r.req.strength_in;
            shadow_seen[slot] = r.req.now_time;
          end
        end else if (shadow_count < TABLE_ENTRIES_DEF) begin
          shadow_dest[shadow_count] = r.req.dest_addr;
          shadow_hop[shadow_count] = r.req.hop_addr_in;
          shadow_hops[shadow_count] = r.req.hops_in;
          shadow_strength[shadow_count] = r.req.strength_in;
          shadow_seen[shadow_count] = r.req.now_time;
          shadow_count++;
        end else begin
          res.status = STATUS_FULL;
        end
      end
      FUNC_FIND: begin
        if (slot >= 0) begin
          report = 1'b1;
        end else begin
          res.status = STATUS_NOT_FOUND;
        end
      end
      FUNC_REFRESH: begin
        if (slot >= 0) begin
          shadow_strength[slot] = r.req.strength_in;
          shadow_seen[slot] = r.req.now_time;
          report = 1'b1;
        end else begin
          res.status = STATUS_NOT_FOUND;
        end
      end
      default: begin
        wr = 0;
        for (int rd = 0; rd < shadow_count; rd++) begin
          age = r.req.now_time - shadow_seen[rd];
          if (age <= shadow_timeout) begin
            shadow_dest[wr] = shadow_dest[rd];
            shadow_hop[wr] = shadow_hop[rd];
            shadow_hops[wr] = shadow_hops[rd];
            shadow_strength[wr] = shadow_strength[rd];
            shadow_seen[wr] = shadow_seen[rd];
            wr++;
          end
        end
        shadow_count = wr;
      end
    endcase
    if (report) begin
      res.hop_addr_out = shadow_hop[slot];
      res.hops_out = shadow_hops[slot];
      res.strength_out = shadow_strength[slot];
      res.seen_out = shadow_seen[slot];
    end
    res.entry_count = shadow_count[4:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t: %s got %0h, wanted %0h", $time, what, got, want);
    end
  endtask

  task automatic queue_request(func_t op, logic [15:0] dest, logic [15:0] hop,
                               logic [7:0] hops, logic [7:0] strength, logic [31:0] now);
    route_request_t r;
    r.op = op;
    r.req.dest_addr = dest;
    r.req.hop_addr_in = hop;
    r.req.hops_in = hops;
    r.req.strength_in = strength;
    r.req.now_time = now;
    queued_requests.push_back(r);
  endtask

  task automatic wait_idle();
    while (queued_requests.size() != 0 || request_on_bus || awaited_replies.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_random_phase(logic [31:0] timeout, int unsigned n_items);
    logic [15:0] addr_pool [24];
    logic [31:0] clock_now;
    int unsigned step;
    int unsigned roll;
    func_t       op;
    logic [15:0] dest;
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= timeout;
    do @(posedge clk); while (!cfg_ready);
    shadow_timeout = timeout;
    cfg_valid <= 1'b0;
    step = (timeout > 32'h3FFF_FFFF) ? 32'h3FFF_FFFF : timeout / 4 + 1;
    clock_now = $urandom;
    foreach (addr_pool[i]) addr_pool[i] = 16'($urandom);
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        op = FUNC_ADD;
      end else if (roll < 65) begin
        op = FUNC_FIND;
      end else if (roll < 85) begin
        op = FUNC_REFRESH;
      end else begin
        op = FUNC_AGE;
      end
      if ($urandom_range(0, 49) == 0) begin
        clock_now = $urandom;
      end else begin
        clock_now = clock_now + $urandom_range(0, step);
      end
      dest = ($urandom_range(0, 9) == 0) ? 16'($urandom) : addr_pool[$urandom_range(0, 23)];
      queue_request(op, dest, 16'($urandom), 8'($urandom), 8'($urandom), clock_now);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_replies.push_back(route_table_step(bus_request));
        request_on_bus = 1'b0;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          bus_request = queued_requests.pop_front();
          request_on_bus = 1'b1;
          in_tdata <= bus_request.req;
          in_tuser <= bus_request.op;
          in_tvalid <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_reply = out_tdata[70:0];
        if (awaited_replies.size() == 0) begin
          report_mismatch("result with none awaited, status", seen_reply.status, '0);
        end else begin
          wanted_reply = awaited_replies.pop_front();
          if (seen_reply.status !== wanted_reply.status)
            report_mismatch("status", seen_reply.status, wanted_reply.status);
          if (seen_reply.hop_addr_out !== wanted_reply.hop_addr_out)
            report_mismatch("hop_addr_out", seen_reply.hop_addr_out, wanted_reply.hop_addr_out);
          if (seen_reply.hops_out !== wanted_reply.hops_out)
            report_mismatch("hops_out", seen_reply.hops_out, wanted_reply.hops_out);
          if (seen_reply.strength_out !== wanted_reply.strength_out)
            report_mismatch("strength_out", seen_reply.strength_out, wanted_reply.strength_out);
          if (seen_reply.seen_out !== wanted_reply.seen_out)
            report_mismatch("seen_out", seen_reply.seen_out, wanted_reply.seen_out);
          if (seen_reply.entry_count !== wanted_reply.entry_count)
            report_mismatch("entry_count", seen_reply.entry_count, wanted_reply.entry_count);
          if (out_tdata[71] !== 1'b0)
            report_mismatch("padding bit", out_tdata[71], '0);
        end
      end
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[5:4])
        2'd0:    out_tready <= 1'b1;
        2'd3:    out_tready <= (stall_tick[1:0] == 2'd0);
        default: out_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes first, then duplicates, a full table and an age-out that compacts.
    queue_request(FUNC_ADD, 16'h0000, 16'h0000, 8'd255, 8'h80, 32'h0000_0000);
    queue_request(FUNC_ADD, 16'hFFFF, 16'hFFFF, 8'd0, 8'h7F, 32'hFFFF_FFFF);
    queue_request(FUNC_FIND, 16'h0000, 16'h0000, 8'd0, 8'h00, 32'h0000_0000);
    queue_request(FUNC_FIND, 16'h1234, 16'h0000, 8'd0, 8'h00, 32'h0000_0000);
    queue_request(FUNC_REFRESH, 16'hFFFF, 16'h1111, 8'd7, 8'h05, 32'hFFFF_FFF0);
    queue_request(FUNC_REFRESH, 16'h5555, 16'h0000, 8'd0, 8'h05, 32'h0000_0010);
    queue_request(FUNC_ADD, 16'h0000, 16'h2222, 8'd255, 8'h02, 32'd50);
    queue_request(FUNC_ADD, 16'h0000, 16'hABCD, 8'd10, 8'h01, 32'd1000);
    queue_request(FUNC_ADD, 16'h0000, 16'h3333, 8'd11, 8'h03, 32'd1100);
    for (int i = 1; i <= 14; i++) begin
      queue_request(FUNC_ADD, 16'(i), 16'(i), 8'(i), 8'(i), (i % 2) ? 32'd700000 : 32'd0);
    end
    queue_request(FUNC_ADD, 16'h0100, 16'h0100, 8'd1, 8'h01, 32'd20);
    queue_request(FUNC_FIND, 16'h000E, 16'h0000, 8'd0, 8'h00, 32'd20);
    queue_request(FUNC_AGE, 16'h0000, 16'h0000, 8'd0, 8'h00, 32'd500);
    queue_request(FUNC_FIND, 16'hFFFF, 16'h0000, 8'd0, 8'h00, 32'd500);

    run_random_phase(32'h0000_0000, 200);
    run_random_phase(32'hFFFF_FFFF, 200);
    run_random_phase(32'd1000, 200);
    run_random_phase($urandom, 200);
    run_random_phase(TIMEOUT_RESET, 200);

    wait_idle();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
